// File: rtl/core/dss_pkg.sv
package dss_pkg;

   localparam int unsigned TABLE_DEPTH = 256;
   localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
   localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int unsigned MODE_W      = 2;
   localparam int unsigned ENERGY_W    = 32;
   localparam int unsigned WEIGHT_W    = 32;
   localparam int unsigned DRAW_W      = 32;
   localparam int unsigned CUM_W       = 40;
   localparam int unsigned SAMPLE_IDX_W = 8;
   localparam int unsigned ENTRY_W     = ENERGY_W + CUM_W;

   localparam int unsigned TOT_HI_W    = CUM_W - DRAW_W;
   localparam int unsigned PROD_LO_W   = 2 * DRAW_W;
   localparam int unsigned PROD_HI_W   = DRAW_W + TOT_HI_W;
   localparam int unsigned THR_W       = CUM_W + 1;

   localparam logic [ENERGY_W-1:0] FALLBACK_RESET = ENERGY_W'(262144);

   typedef enum logic [MODE_W-1:0] {
      MODE_CLEAR  = 2'd0,
      MODE_APPEND = 2'd1,
      MODE_SAMPLE = 2'd2
   } mode_type;

endpackage

// File: rtl/core/dss_ram.sv
module dss_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/discrete_spectrum_sampler.sv
// Inverse-CDF sampler over a table of (energy, weight) entries held in one
// synchronous RAM as (energy, cumulative weight) pairs. Clear and append
// commands keep busy low. A sample on a non-empty table raises busy while
// the MULT and THRESH states form the threshold r*total, then a binary
// search performs one dependent RAM read per step, then the chosen entry is
// read in FETCH. A sample on an empty table answers with the fallback
// energy in the cycle after start. Each result is shown for a single cycle
// under rsp_valid and cannot be held off, so the receiver must take it in
// that cycle.
module discrete_spectrum_sampler (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [dss_pkg::MODE_W-1:0]        req_mode,
   input  logic [dss_pkg::ENERGY_W-1:0]      req_entry_energy,
   input  logic [dss_pkg::WEIGHT_W-1:0]      req_entry_weight,
   input  logic [dss_pkg::DRAW_W-1:0]        req_uniform_draw,
   output logic                              rsp_valid,
   output logic [dss_pkg::ENERGY_W-1:0]      rsp_sample_energy,
   output logic [dss_pkg::SAMPLE_IDX_W-1:0]  rsp_sample_index,
   output logic                              rsp_used_fallback,
   output logic                              rsp_table_overflowed,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dss_pkg::ENERGY_W-1:0]      csr_data
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_MULT   = 5'b00010,
      ST_THRESH = 5'b00100,
      ST_SEARCH = 5'b01000,
      ST_FETCH  = 5'b10000
   } state_type;

   state_type                          state_ff, state_in;
   logic [dss_pkg::CNT_W-1:0]          count_ff, count_in;
   logic [dss_pkg::CUM_W-1:0]          total_ff, total_in;
   logic                               ovf_ff, ovf_in;
   logic [dss_pkg::ENERGY_W-1:0]       fallback_ff, fallback_in;
   logic [dss_pkg::DRAW_W-1:0]         draw_ff, draw_in;
   logic [dss_pkg::PROD_LO_W-1:0]      prod_lo_ff, prod_lo_in;
   logic [dss_pkg::PROD_HI_W-1:0]      prod_hi_ff, prod_hi_in;
   logic [dss_pkg::THR_W-1:0]          thr_ff, thr_in;
   logic [dss_pkg::IDX_W-1:0]          lo_ff, lo_in;
   logic [dss_pkg::IDX_W-1:0]          hi_ff, hi_in;
   logic [dss_pkg::IDX_W-1:0]          mid_ff, mid_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [dss_pkg::ENERGY_W-1:0]       rsp_energy_ff, rsp_energy_in;
   logic [dss_pkg::SAMPLE_IDX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic                               rsp_fallback_ff, rsp_fallback_in;
   logic                               rsp_ovf_ff, rsp_ovf_in;

   logic                               accept;
   logic                               table_full;
   logic                               empty_sample;
   logic [dss_pkg::CUM_W:0]            total_sum;
   logic [dss_pkg::CUM_W-1:0]          cum_new;
   logic                               ram_we;
   logic [dss_pkg::IDX_W-1:0]          ram_waddr;
   logic [dss_pkg::ENTRY_W-1:0]        ram_wdata;
   logic [dss_pkg::IDX_W-1:0]          ram_raddr;
   logic [dss_pkg::ENTRY_W-1:0]        ram_rdata;
   logic [dss_pkg::ENERGY_W-1:0]       rd_energy;
   logic [dss_pkg::CUM_W-1:0]          rd_cum;
   logic                               reach;
   logic [dss_pkg::IDX_W:0]            mid_sum;
   logic [dss_pkg::IDX_W-1:0]          step_lo;
   logic [dss_pkg::IDX_W-1:0]          step_hi;

   assign accept       = start && !busy;
   assign busy         = (state_ff != ST_IDLE);
   assign csr_ready    = 1'b1;
   assign table_full   = (count_ff >= dss_pkg::CNT_W'(dss_pkg::TABLE_DEPTH));
   assign empty_sample = accept && (req_mode == dss_pkg::MODE_SAMPLE) &&
                         (count_ff == '0);

   assign total_sum = {1'b0, total_ff} +
                      (dss_pkg::CUM_W + 1)'(req_entry_weight);
   assign cum_new   = total_sum[dss_pkg::CUM_W] ? '1 : total_sum[dss_pkg::CUM_W-1:0];

   assign ram_we    = accept && (req_mode == dss_pkg::MODE_APPEND) && !table_full;
   assign ram_waddr = count_ff[dss_pkg::IDX_W-1:0];
   assign ram_wdata = {req_entry_energy, cum_new};

   assign rd_energy = ram_rdata[dss_pkg::ENTRY_W-1:dss_pkg::CUM_W];
   assign rd_cum    = ram_rdata[dss_pkg::CUM_W-1:0];
   assign reach     = ({1'b0, rd_cum} >= thr_ff);

   always_comb begin
      step_lo = lo_ff;
      step_hi = hi_ff;
      if (state_ff == ST_SEARCH) begin
         if (reach) begin
            step_hi = mid_ff;
         end else begin
            step_lo = mid_ff + 1'b1;
         end
      end
   end

   assign mid_sum = {1'b0, step_lo} + {1'b0, step_hi};

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      total_in        = total_ff;
      ovf_in          = ovf_ff;
      fallback_in     = fallback_ff;
      draw_in         = draw_ff;
      prod_lo_in      = prod_lo_ff;
      prod_hi_in      = prod_hi_ff;
      thr_in          = thr_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      mid_in          = mid_ff;
      ram_raddr       = mid_ff;
      rsp_valid_in    = 1'b0;
      rsp_energy_in   = rsp_energy_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_fallback_in = rsp_fallback_ff;
      rsp_ovf_in      = rsp_ovf_ff;

      if (csr_valid && csr_ready) begin
         fallback_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  dss_pkg::MODE_CLEAR: begin
                     count_in = '0;
                     total_in = '0;
                     ovf_in   = 1'b0;
                  end
                  dss_pkg::MODE_APPEND: begin
                     if (table_full) begin
                        ovf_in = 1'b1;
                     end else begin
                        total_in = cum_new;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  dss_pkg::MODE_SAMPLE: begin
                     if (count_ff == '0) begin
                        rsp_valid_in    = 1'b1;
                        rsp_energy_in   = fallback_ff;
                        rsp_index_in    = '0;
                        rsp_fallback_in = 1'b1;
                        rsp_ovf_in      = ovf_ff;
                     end else begin
                        draw_in  = req_uniform_draw;
                        lo_in    = '0;
                        hi_in    = dss_pkg::IDX_W'(count_ff - 1'b1);
                        state_in = ST_MULT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MULT: begin
            prod_lo_in = dss_pkg::PROD_LO_W'(draw_ff) *
                         dss_pkg::PROD_LO_W'(total_ff[dss_pkg::DRAW_W-1:0]);
            prod_hi_in = dss_pkg::PROD_HI_W'(draw_ff) *
                         dss_pkg::PROD_HI_W'(total_ff[dss_pkg::CUM_W-1:dss_pkg::DRAW_W]);
            state_in   = ST_THRESH;
         end
         ST_THRESH, ST_SEARCH: begin
            if (state_ff == ST_THRESH) begin
               thr_in = dss_pkg::THR_W'(prod_hi_ff) +
                        dss_pkg::THR_W'(prod_lo_ff[dss_pkg::PROD_LO_W-1:dss_pkg::DRAW_W]) +
                        dss_pkg::THR_W'(prod_lo_ff[dss_pkg::DRAW_W-1:0] != '0);
            end
            lo_in = step_lo;
            hi_in = step_hi;
            if (step_lo < step_hi) begin
               mid_in    = mid_sum[dss_pkg::IDX_W:1];
               ram_raddr = mid_sum[dss_pkg::IDX_W:1];
               state_in  = ST_SEARCH;
            end else begin
               ram_raddr = step_lo;
               state_in  = ST_FETCH;
            end
         end
         ST_FETCH: begin
            rsp_valid_in    = 1'b1;
            rsp_energy_in   = rd_energy;
            rsp_index_in    = dss_pkg::SAMPLE_IDX_W'(lo_ff);
            rsp_fallback_in = 1'b0;
            rsp_ovf_in      = ovf_ff;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         fallback_ff  <= dss_pkg::FALLBACK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         fallback_ff  <= fallback_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      draw_ff         <= draw_in;
      prod_lo_ff      <= prod_lo_in;
      prod_hi_ff      <= prod_hi_in;
      thr_ff          <= thr_in;
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      mid_ff          <= mid_in;
      rsp_energy_ff   <= rsp_energy_in;
      rsp_index_ff    <= rsp_index_in;
      rsp_fallback_ff <= rsp_fallback_in;
      rsp_ovf_ff      <= rsp_ovf_in;
   end

   dss_ram #(
      .WIDTH (dss_pkg::ENTRY_W),
      .DEPTH (dss_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_sample_energy    = rsp_energy_ff;
   assign rsp_sample_index     = rsp_index_ff;
   assign rsp_used_fallback    = rsp_fallback_ff;
   assign rsp_table_overflowed = rsp_ovf_ff;

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == ST_FETCH) || $past(empty_sample))
      else $error("result beat without a finished search or empty sample");

   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |->
         (lo_ff <= mid_ff) && (mid_ff < hi_ff) &&
         (dss_pkg::CNT_W'(hi_ff) < count_ff))
      else $error("search window outside the filled table");

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= dss_pkg::CNT_W'(dss_pkg::TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_count_frozen: assert property (@(posedge clock) disable iff (reset)
      busy && $past(busy) |-> $stable(count_ff) && $stable(total_ff))
      else $error("table changed during a sample");

endmodule
